// ----- rtl/tgad_pkg.sv -----
`default_nettype none

package tgad_pkg;

    // Four 32-bit registers at byte addresses 0, 4, 8 and 12.
    localparam int unsigned CfgAddrW = 4;

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_RLE_ENABLED  = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_reg;

    // Pixel format codes. Codes above the last one decode as gray8.
    localparam logic [2:0] FMT_GRAY8    = 3'd0;
    localparam logic [2:0] FMT_RGB555   = 3'd1;
    localparam logic [2:0] FMT_ARGB1555 = 3'd2;
    localparam logic [2:0] FMT_BGR24    = 3'd3;
    localparam logic [2:0] FMT_BGRA32   = 3'd4;

    localparam logic [2:0]  RST_PIXEL_FORMAT = FMT_BGR24;
    localparam logic        RST_RLE_ENABLED  = 1'b0;
    localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd1;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;

    localparam logic [7:0] RLE_COUNT_MASK = 8'h7F;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_count;
        logic [31:0] first_pixel_index;
        logic        image_done;
    } t_out_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
        logic [2:0] n;
        case (fmt) inside
            FMT_RGB555, FMT_ARGB1555: n = 3'd2;
            FMT_BGR24:                n = 3'd3;
            FMT_BGRA32:               n = 3'd4;
            default:                  n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tgad_in_if.sv -----
`default_nettype none

interface tgad_in_if;
    import tgad_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tgad_out_if.sv -----
`default_nettype none

interface tgad_out_if;
    import tgad_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tgad_colour_conv.sv -----
`default_nettype none

module tgad_colour_conv (
    input  logic [2:0]          i_format,
    input  logic [3:0][7:0]     i_bytes,
    output tgad_pkg::t_rgba     o_colour
);
    import tgad_pkg::*;

    logic [15:0] word16;

    assign word16 = {i_bytes[1], i_bytes[0]};

    always_comb begin
        o_colour.alpha = ALPHA_OPAQUE;
        case (i_format) inside
            FMT_RGB555, FMT_ARGB1555: begin
                o_colour.red   = {word16[14:10], 3'b000};
                o_colour.green = {word16[9:5], 3'b000};
                o_colour.blue  = {word16[4:0], 3'b000};
                // Only the top bit of the word carries alpha.
                if (i_format == FMT_ARGB1555) begin
                    o_colour.alpha = word16[15] ? ALPHA_OPAQUE : 8'h00;
                end
            end
            FMT_BGR24, FMT_BGRA32: begin
                o_colour.red   = i_bytes[2];
                o_colour.green = i_bytes[1];
                o_colour.blue  = i_bytes[0];
                if (i_format == FMT_BGRA32) begin
                    o_colour.alpha = i_bytes[3];
                end
            end
            default: begin
                o_colour.red   = i_bytes[0];
                o_colour.green = i_bytes[0];
                o_colour.blue  = i_bytes[0];
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tga_pixel_stream_decoder_unit.sv -----
`default_nettype none

// TGA pixel-field decoder. Bytes of the pixel field enter on i_pix one word per
// cycle, and each finished pixel leaves on o_pix as 8-bit RGBA with its run
// count, the row-major index of its first pixel and an image_done flag. A word
// passes an input register and the decode logic and reaches the output
// register, which drives o_pix directly, and the block sustains one byte per
// cycle as long as o_pix keeps taking results; headers and leading bytes of
// multi-byte pixels give no result. Set start_of_image on the first byte of
// each image. The registers pixel_format (0x0), rle_enabled (0x4),
// image_width (0x8) and image_height (0xC) are to be written over the APB port
// only while no byte is in flight; the block does not enforce this. Every
// write also recomputes the stored pixel total width*height.
module tga_pixel_stream_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tgad_in_if.sink                         i_pix,
    tgad_out_if.source                      o_pix,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgad_pkg::CfgAddrW-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tgad_pkg::*;

    // Configuration.
    logic [2:0]  r_format;
    logic        r_rle;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_total;

    t_cfg_reg    cfg_sel;
    logic        cfg_wr;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] mul_p;

    // Input stage.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      in_ready;
    logic      consume;

    // Decoder state.
    logic        r_expect_hdr, n_expect_hdr;
    logic        r_repeat, n_repeat;
    logic [7:0]  r_remain, n_remain;
    logic [1:0]  r_bip, n_bip;
    logic [23:0] r_pix_bytes, n_pix_bytes;
    logic [31:0] r_pos, n_pos;
    logic        r_finished, n_finished;

    // Output stage.
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;
    logic      emit;

    // Values after a possible start-of-image clear.
    logic        sof;
    logic [7:0]  in_byte;
    logic        e_expect_hdr;
    logic        e_repeat;
    logic [7:0]  e_remain;
    logic [1:0]  e_bip;
    logic [23:0] e_pix_bytes;
    logic [31:0] e_pos;
    logic        e_finished;

    logic [2:0]      need;
    logic [1:0]      last_idx;
    logic [3:0][7:0] pix;
    t_rgba           colour;
    logic [31:0]     left;
    logic [7:0]      run;
    logic [7:0]      remain_next;
    logic            clip;
    logic            reach;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_sel = t_cfg_reg'(paddr[CfgAddrW-1:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    // The pixel total is kept up to date from the value being written, so it
    // is valid the cycle after the write.
    assign mul_a = (cfg_sel == CFG_IMAGE_WIDTH)  ? pwdata[15:0] : r_width;
    assign mul_b = (cfg_sel == CFG_IMAGE_HEIGHT) ? pwdata[15:0] : r_height;
    assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= RST_PIXEL_FORMAT;
            r_rle    <= RST_RLE_ENABLED;
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_total  <= {16'd0, RST_IMAGE_WIDTH} * {16'd0, RST_IMAGE_HEIGHT};
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                CFG_PIXEL_FORMAT: r_format <= pwdata[2:0];
                CFG_RLE_ENABLED:  r_rle    <= pwdata[0];
                CFG_IMAGE_WIDTH:  r_width  <= pwdata[15:0];
                CFG_IMAGE_HEIGHT: r_height <= pwdata[15:0];
                default: ;
            endcase
            r_total <= mul_p;
        end
    end

    always_comb begin
        unique case (cfg_sel)
            CFG_PIXEL_FORMAT: prdata = {29'd0, r_format};
            CFG_RLE_ENABLED:  prdata = {31'd0, r_rle};
            CFG_IMAGE_WIDTH:  prdata = {16'd0, r_width};
            CFG_IMAGE_HEIGHT: prdata = {16'd0, r_height};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    assign consume     = r_in_valid & (~r_out_valid | o_pix.ready);
    assign in_ready    = ~r_in_valid | consume;
    assign i_pix.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_pix.valid) begin
            r_in <= i_pix.data;
        end
    end

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign sof     = r_in.start_of_image;
    assign in_byte = r_in.data_byte;

    assign e_expect_hdr = sof | r_expect_hdr;
    assign e_repeat     = sof ? 1'b0  : r_repeat;
    assign e_remain     = sof ? 8'd0  : r_remain;
    assign e_bip        = sof ? 2'd0  : r_bip;
    assign e_pix_bytes  = sof ? 24'd0 : r_pix_bytes;
    assign e_pos        = sof ? 32'd0 : r_pos;
    assign e_finished   = sof ? 1'b0  : r_finished;

    assign need     = bytes_per_pixel(r_format);
    assign last_idx = 2'(need - 3'd1);

    // The byte that completes a pixel takes the place of the format's last
    // byte; anything missing reads as what was stored.
    always_comb begin
        pix[0] = e_pix_bytes[7:0];
        pix[1] = e_pix_bytes[15:8];
        pix[2] = e_pix_bytes[23:16];
        pix[3] = 8'd0;
        pix[last_idx] = in_byte;
    end

    tgad_colour_conv u_colour_conv (
        .i_format (r_format),
        .i_bytes  (pix),
        .o_colour (colour)
    );

    // Run length from the packet state. An empty count gives a run of one.
    always_comb begin
        run         = 8'd1;
        remain_next = e_remain;
        if (r_rle) begin
            if (e_repeat && (e_remain != 8'd0)) begin
                run = e_remain;
            end
            if (e_repeat || (e_remain <= 8'd1)) begin
                remain_next = 8'd0;
            end else begin
                remain_next = e_remain - 8'd1;
            end
        end
    end

    assign left  = r_total - e_pos;
    assign clip  = (left[31:8] == 24'd0) && (left[7:0] < run);
    assign reach = (left[31:8] == 24'd0) && (left[7:0] <= run);

    always_comb begin
        n_expect_hdr = r_expect_hdr;
        n_repeat     = r_repeat;
        n_remain     = r_remain;
        n_bip        = r_bip;
        n_pix_bytes  = r_pix_bytes;
        n_pos        = r_pos;
        n_finished   = r_finished;
        emit         = 1'b0;

        n_out.red               = colour.red;
        n_out.green             = colour.green;
        n_out.blue              = colour.blue;
        n_out.alpha             = colour.alpha;
        n_out.run_count         = clip ? left[7:0] : run;
        n_out.first_pixel_index = e_pos;
        n_out.image_done        = reach;

        if (consume) begin
            n_expect_hdr = e_expect_hdr;
            n_repeat     = e_repeat;
            n_remain     = e_remain;
            n_bip        = e_bip;
            n_pix_bytes  = e_pix_bytes;
            n_pos        = e_pos;
            n_finished   = e_finished;

            if (e_finished || (e_pos >= r_total)) begin
                // Bytes past the last pixel, or a zero-sized image.
                if (r_total != 32'd0) begin
                    n_finished = 1'b1;
                end
            end else if (r_rle && e_expect_hdr) begin
                n_remain     = (in_byte & RLE_COUNT_MASK) + 8'd1;
                n_repeat     = in_byte[7];
                n_expect_hdr = 1'b0;
                n_bip        = 2'd0;
            end else if (({1'b0, e_bip} + 3'd1) < need) begin
                case (e_bip)
                    2'd0:    n_pix_bytes[7:0]   = in_byte;
                    2'd1:    n_pix_bytes[15:8]  = in_byte;
                    default: n_pix_bytes[23:16] = in_byte;
                endcase
                n_bip = e_bip + 2'd1;
            end else begin
                emit        = 1'b1;
                n_bip       = 2'd0;
                n_pix_bytes = 24'd0;
                if (r_rle) begin
                    n_remain = remain_next;
                    if (remain_next == 8'd0) begin
                        n_expect_hdr = 1'b1;
                    end
                end
                n_pos      = clip ? r_total : (e_pos + {24'd0, run});
                n_finished = reach;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_repeat     <= 1'b0;
            r_remain     <= 8'd0;
            r_bip        <= 2'd0;
            r_pix_bytes  <= 24'd0;
            r_pos        <= 32'd0;
            r_finished   <= 1'b0;
        end else begin
            r_expect_hdr <= n_expect_hdr;
            r_repeat     <= n_repeat;
            r_remain     <= n_remain;
            r_bip        <= n_bip;
            r_pix_bytes  <= n_pix_bytes;
            r_pos        <= n_pos;
            r_finished   <= n_finished;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (~r_out_valid | o_pix.ready) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

endmodule

`default_nettype wire
